### rtl/bli_pkg.sv
// Shared constants, codes and types of the bounded list core.
package bli_pkg;

    localparam int CAPACITY = 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DEPTH    = 2 ** AW;
    localparam int VW       = 32;
    localparam int PW       = 8;
    localparam int FW       = 2;

    typedef enum logic [FW-1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_PUSH_BACK  = 2'd1,
        FN_DELETE     = 2'd2,
        FN_REPORT     = 2'd3
    } t_func;

    // Store access request from the sequencer.
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [VW-1:0] wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;

    // One result handed to the output register.
    typedef struct packed {
        logic                 valid;
        logic signed [VW-1:0] entry_value;
        logic                 is_last;
        logic                 list_empty;
        logic                 dropped;
    } t_res;

endpackage

### rtl/bli_ifs.sv
// Query and result channel interfaces.
interface bli_in_if import bli_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [FW-1:0]        func;
    logic signed [VW-1:0] item_value;
    logic [PW-1:0]        position;

    modport source (output valid, output func, output item_value, output position,
                    input ready);
    modport sink   (input valid, input func, input item_value, input position,
                    output ready);
endinterface

interface bli_out_if import bli_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [VW-1:0] entry_value;
    logic                 is_last;
    logic                 list_empty;
    logic                 dropped;

    modport source (output valid, output entry_value, output is_last,
                    output list_empty, output dropped, input ready);
    modport sink   (input valid, input entry_value, input is_last,
                    input list_empty, input dropped, output ready);
endinterface

### rtl/bli_store.sv
// Entry store: one write port, one read port, registered read data.
module bli_store import bli_pkg::*; (
    input  logic          i_clk,
    input  t_mem_req      i_req,
    output logic [VW-1:0] o_rdata
);

    logic [VW-1:0] r_mem [DEPTH];
    logic [VW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/bli_seq.sv
// Query sequencer: updates the circular store, compacts on delete, streams the listing.
module bli_seq import bli_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bli_in_if.sink        i_in,
    input  logic          i_out_free,
    input  logic [VW-1:0] i_rdata,
    output t_mem_req      o_req,
    output t_res          o_res
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_LIST  = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_ridx,  n_ridx;
    logic          r_wv,    n_wv;
    logic [CW-1:0] r_lidx,  n_lidx;
    logic          r_dv,    n_dv;
    logic          r_drop,  n_drop;

    logic full;
    logic pos_ok;
    logic accept;

    assign full   = (r_count >= CW'(CAPACITY));
    assign pos_ok = ({1'b0, i_in.position} < (PW + 1)'(r_count));
    assign accept = i_in.valid && (r_state == S_IDLE);
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_head  = r_head;
        n_ridx  = r_ridx;
        n_wv    = r_wv;
        n_lidx  = r_lidx;
        n_dv    = r_dv;
        n_drop  = r_drop;
        o_req   = '0;
        o_res   = '0;
        case (r_state)
            S_IDLE: begin
                o_req.raddr = r_head;
                if (i_in.valid) begin
                    n_drop  = 1'b0;
                    n_lidx  = '0;
                    n_dv    = 1'b0;
                    n_state = S_LIST;
                    o_req.wdata = i_in.item_value;
                    case (t_func'(i_in.func))
                        FN_PUSH_FRONT: begin
                            if (full) begin
                                n_drop = 1'b1;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.waddr = r_head - AW'(1);
                                n_head      = r_head - AW'(1);
                                n_count     = r_count + CW'(1);
                            end
                        end
                        FN_PUSH_BACK: begin
                            if (full) begin
                                n_drop = 1'b1;
                            end else begin
                                o_req.we    = 1'b1;
                                o_req.waddr = r_head + AW'(r_count);
                                n_count     = r_count + CW'(1);
                            end
                        end
                        FN_DELETE: begin
                            if (pos_ok) begin
                                n_ridx  = CW'(i_in.position) + CW'(1);
                                n_wv    = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // read entry k, write it to slot k-1 in the next cycle
                o_req.raddr = r_head + AW'(r_ridx);
                o_req.we    = r_wv;
                o_req.waddr = r_head + AW'(r_ridx - CW'(2));
                o_req.wdata = i_rdata;
                if (r_ridx == r_count) begin
                    n_count = r_count - CW'(1);
                    n_wv    = 1'b0;
                    n_state = S_LIST;
                end else begin
                    n_ridx = r_ridx + CW'(1);
                    n_wv   = 1'b1;
                end
            end
            S_LIST: begin
                o_res.dropped = r_drop;
                if (r_count == '0) begin
                    o_res.list_empty = 1'b1;
                    o_res.is_last    = 1'b1;
                    o_res.valid      = i_out_free;
                    if (i_out_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_res.entry_value = i_rdata;
                    o_res.is_last     = (r_lidx == r_count - CW'(1));
                    o_res.valid       = r_dv && i_out_free;
                    n_dv              = 1'b1;
                    if (r_dv && i_out_free) begin
                        n_lidx = r_lidx + CW'(1);
                        if (o_res.is_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
                o_req.raddr = r_head + AW'(n_lidx);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_wv    <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_wv    <= n_wv;
            r_dv    <= n_dv;
        end
        r_ridx <= n_ridx;
        r_lidx <= n_lidx;
        r_drop <= n_drop;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_res_only_listing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_state == S_LIST))
        else $error("result issued outside listing");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && (t_func'(i_in.func) == FN_PUSH_BACK))
            |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the list");

    a_shift_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_ridx <= r_count) && (r_ridx != '0))
        else $error("compaction index out of range");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && (r_ridx == r_count))
            |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the list");
`endif

endmodule

### rtl/bounded_list_insert_delete_core.sv
// Top level of the bounded list core: sequencer, entry store and result register.
//
//  channel  | dir | transfer when          | payload
//  ---------+-----+------------------------+-----------------------------------------
//  i_in     | in  | valid & ready          | func, item_value, position
//  o_out    | out | valid & ready          | entry_value, is_last, list_empty, dropped
//
// A query is taken from i_in; insert and append write the store in that same cycle.
// Delete then compacts the entries behind the position through the store's one read
// and one write port. The listing then streams one entry per cycle while o_out is not
// stalled, after a first read. Synchronous reset empties the list; the store itself is
// never cleared. A stall on o_out holds the listing; a new query is taken while the last
// result waits.
module bounded_list_insert_delete_core import bli_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bli_in_if.sink    i_in,
    bli_out_if.source o_out
);

    t_mem_req      mem_req;
    logic [VW-1:0] mem_rdata;
    t_res          res;
    logic          out_free;

    // result register, one deep
    logic          r_ovalid;
    t_res          r_res;

    assign out_free = !r_ovalid || o_out.ready;

    bli_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_free (out_free),
        .i_rdata    (mem_rdata),
        .o_req      (mem_req),
        .o_res      (res)
    );

    bli_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.valid) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (res.valid) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.entry_value = r_res.entry_value;
    assign o_out.is_last     = r_res.is_last;
    assign o_out.list_empty  = r_res.list_empty;
    assign o_out.dropped     = r_res.dropped;

endmodule
